// ----- rtl/core/wbps_pkg.sv -----
package wbps_pkg;

	localparam int PAT_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int ADDR_W     = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

	typedef struct packed {
		logic [63:0]          pattern_bytes_low;
		logic [63:0]          pattern_bytes_high;
		logic [PAT_BYTES-1:0] wildcard_mask;
		logic [LEN_W-1:0]     pat_len;
		logic [ADDR_W-1:0]    image_base;
		logic [ADDR_W-1:0]    result_offset;
	} cfg_t;

	typedef struct packed {
		logic              emit;
		logic              found;
		logic [ADDR_W-1:0] addr;
	} res_t;

endpackage

// ----- rtl/core/wbps_cfg.sv -----
module wbps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output wbps_pkg::cfg_t                 cfg
);
	import wbps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LOW:  cfg_q.pattern_bytes_low  <= cfg_wdata;
				REG_PAT_HIGH: cfg_q.pattern_bytes_high <= cfg_wdata;
				REG_WILDCARD: cfg_q.wildcard_mask      <= cfg_wdata[PAT_BYTES-1:0];
				REG_PAT_LEN:  cfg_q.pat_len            <= cfg_wdata[LEN_W-1:0];
				REG_BASE:     cfg_q.image_base         <= cfg_wdata[ADDR_W-1:0];
				REG_OFFSET:   cfg_q.result_offset      <= cfg_wdata[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/wbps_match.sv -----
module wbps_match #(
	parameter int MAX_PATTERN = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wbps_pkg::cfg_t     cfg,
	input  logic               step,
	input  wbps_pkg::in_item_t item,
	output wbps_pkg::res_t     res
);
	import wbps_pkg::*;

	localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic [7:0]           window_q  [MAX_PATTERN];
	logic [7:0]           window_nx [MAX_PATTERN];
	logic [ADDR_W-1:0]    index_q;
	logic [ADDR_W-1:0]    index_nx;
	logic                 reported_q;
	logic [PAT_BYTES-1:0] byte_ok;
	logic                 len_ok;
	logic                 hit;
	logic [ADDR_W-1:0]    start;
	logic [2*64-1:0]      pattern;

	assign pattern = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

	always_comb begin
		window_nx[0] = item.data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			window_nx[k] = window_q[k-1];
		end
	end

	assign index_nx = index_q + ADDR_W'(1);
	assign len_ok = (cfg.pat_len != '0) && (cfg.pat_len <= MAX_LEN)
		&& (index_nx >= ADDR_W'(cfg.pat_len));

	// Pattern byte j lines up with the window entry len-1-j (entry 0 is newest).
	always_comb begin
		logic [LEN_W-1:0] k_idx;
		k_idx = '0;
		for (int j = 0; j < PAT_BYTES; j++) begin
			k_idx = cfg.pat_len - LEN_W'(j) - LEN_W'(1);
			byte_ok[j] = (LEN_W'(j) >= cfg.pat_len) || cfg.wildcard_mask[j]
				|| (window_nx[k_idx[WIN_IDX_W-1:0]] == pattern[8*j +: 8]);
		end
	end

	assign hit   = len_ok && (&byte_ok);
	assign start = index_nx - ADDR_W'(cfg.pat_len);

	always_comb begin
		res.emit  = step && !reported_q && (hit || item.last_byte);
		res.found = hit;
		res.addr  = hit ? (cfg.image_base + start + cfg.result_offset) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				window_q[k] <= '0;
			end
			index_q    <= '0;
			reported_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					window_q[k] <= '0;
				end
				index_q    <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				window_q <= window_nx;
				index_q  <= index_nx;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	a_no_result_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		step && reported_q |-> !res.emit)
		else $error("result emitted after the image already matched");

	a_rearm_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> !reported_q && (index_q == '0))
		else $error("scanner did not re-arm after the last byte");

	a_match_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reported_q) |-> $past(res.emit && res.found))
		else $error("match flag set without a reported match");

endmodule

// ----- rtl/core/wildcard_byte_pattern_scanner_core.sv -----
// Wildcard byte pattern scanner.
// Configure the pattern, wildcard mask, length, image base and result offset
// through the write port while the block is idle; a write takes effect at once.
// Stream the image bytes on the input channel, one byte per item, with
// last_byte set on the final byte. At the first full match the block emits one
// item with found set and the match address; the rest of that image produces
// nothing. An image that ends without a match emits one item with found clear
// and address zero. The block re-arms after every final byte.
// The result item is registered after its input item passes the input register
// and the processing stage. Throughput is one byte per cycle while the receiver
// does not stall, set by the single processing stage that shifts the window and
// compares all pattern bytes. When the receiver stalls with a result held, the
// processing stage waits and the input register holds one more item before
// in_ready drops. Reset clears the configuration to zero, empties both pipeline
// registers, and clears the byte window, byte count and match flag.
module wildcard_byte_pattern_scanner_core #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wbps_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wbps_pkg::out_item_t             out_item,
	input  logic                            cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wbps_pkg::*;

	cfg_t      cfg;
	res_t      res;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      s1_fire;
	logic      out_valid_q;
	out_item_t out_item_q;

	wbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (s1_fire),
		.item   (item_s1),
		.res    (res)
	);

	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res.emit) begin
			out_item_q.found         <= res.found;
			out_item_q.match_address <= res.addr;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(item_s1))
		else $error("stalled item lost from the input register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input not ready while the input register is empty");

	a_miss_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_item_q.found |-> out_item_q.match_address == '0)
		else $error("no-match result carries a nonzero address");

endmodule

// ----- tb/signature_scan_checker.sv -----
`timescale 1ns / 1ps

module signature_scan_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  wbps_pkg::in_item_t              in_item,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  wbps_pkg::out_item_t             out_item,
	input  logic                            cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              results_due,
	output int                              mismatch_count
);
	import wbps_pkg::*;

	cfg_t              regs;
	logic [7:0]        window [PAT_BYTES];
	logic [ADDR_W-1:0] byte_count;
	logic              match_seen;
	out_item_t         scan_results_due [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic clear_window();
		for (int k = 0; k < PAT_BYTES; k++) begin
			window[k] = 8'h00;
		end
		byte_count = '0;
		match_seen = 1'b0;
	endtask

	function automatic bit window_hit();
		logic [127:0] pattern;
		int len;
		pattern = {regs.pattern_bytes_high, regs.pattern_bytes_low};
		len = regs.pat_len;
		if (len == 0 || len > PAT_BYTES || byte_count < len) begin
			return 1'b0;
		end
		for (int j = 0; j < len; j++) begin
			if (!regs.wildcard_mask[j] && window[len - 1 - j] != pattern[8 * j +: 8]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_PAT_LOW: begin
				regs.pattern_bytes_low = data;
			end
			REG_PAT_HIGH: begin
				regs.pattern_bytes_high = data;
			end
			REG_WILDCARD: begin
				regs.wildcard_mask = data[PAT_BYTES-1:0];
			end
			REG_PAT_LEN: begin
				regs.pat_len = data[LEN_W-1:0];
			end
			REG_BASE: begin
				regs.image_base = data[ADDR_W-1:0];
			end
			REG_OFFSET: begin
				regs.result_offset = data[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic scan_byte(input in_item_t item);
		out_item_t result;
		if (!match_seen) begin
			for (int k = PAT_BYTES - 1; k > 0; k--) begin
				window[k] = window[k - 1];
			end
			window[0] = item.data_byte;
			byte_count = byte_count + 1'b1;
			if (window_hit()) begin
				result.found = 1'b1;
				result.match_address = regs.image_base
					+ (byte_count - ADDR_W'(regs.pat_len)) + regs.result_offset;
				match_seen = 1'b1;
				scan_results_due = {scan_results_due, result};
			end else if (item.last_byte) begin
				result = '0;
				scan_results_due = {scan_results_due, result};
			end
		end
		if (item.last_byte) begin
			clear_window();
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (scan_results_due.size() == 0) begin
			report_mismatch("unexpected result", got.match_address, '0);
		end else begin
			want = scan_results_due.pop_front();
			if (got.found !== want.found) begin
				report_mismatch("found", 32'(got.found), 32'(want.found));
			end
			if (got.match_address !== want.match_address) begin
				report_mismatch("match_address", got.match_address, want.match_address);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			clear_window();
			scan_results_due.delete();
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				write_register(cfg_index, cfg_wdata);
			end
			if (in_valid && in_ready) begin
				scan_byte(in_item);
			end
			if (out_valid && out_ready) begin
				check_result(out_item);
			end
			results_due <= scan_results_due.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import wbps_pkg::*;

	localparam int ITEM_TARGET  = 1900;
	localparam int DRAIN_CYCLES = 6;
	localparam int QUIET_LIMIT  = 1000;
	localparam logic [7:0] ALPHABET [4] = '{8'h00, 8'hA5, 8'h5A, 8'hFF};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int                    results_due;
	int                    mismatch_count;
	int                    items_sent = 0;
	int                    quiet_cycles = 0;
	bit                    tx_burst = 1'b0;
	bit                    rx_burst = 1'b0;

	always #6 clk = ~clk;

	wildcard_byte_pattern_scanner_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	signature_scan_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.results_due    (results_due),
		.mismatch_count (mismatch_count)
	);

	function automatic logic [7:0] fill_byte(input bit narrow);
		return narrow ? ALPHABET[$urandom_range(0, 3)] : 8'($urandom);
	endfunction

	function automatic cfg_t random_setup(input bit narrow);
		cfg_t c;
		for (int j = 0; j < 8; j++) begin
			c.pattern_bytes_low[8 * j +: 8] = fill_byte(narrow);
			c.pattern_bytes_high[8 * j +: 8] = fill_byte(narrow);
		end
		case ($urandom_range(0, 7))
			0, 1, 2, 3: begin
				c.wildcard_mask = 16'($urandom & $urandom & $urandom);
			end
			4: begin
				c.wildcard_mask = '0;
			end
			5: begin
				c.wildcard_mask = '1;
			end
			default: begin
				c.wildcard_mask = 16'($urandom);
			end
		endcase
		case ($urandom_range(0, 11))
			0, 1, 2, 3, 4, 5, 6: begin
				c.pat_len = LEN_W'($urandom_range(1, 4));
			end
			7, 8: begin
				c.pat_len = LEN_W'($urandom_range(5, PAT_BYTES));
			end
			9: begin
				c.pat_len = LEN_W'(PAT_BYTES);
			end
			10: begin
				c.pat_len = '0;
			end
			default: begin
				c.pat_len = LEN_W'($urandom_range(PAT_BYTES + 1, 31));
			end
		endcase
		case ($urandom_range(0, 3))
			0: begin
				c.image_base = '0;
			end
			1: begin
				c.image_base = '1;
			end
			default: begin
				c.image_base = $urandom;
			end
		endcase
		case ($urandom_range(0, 3))
			0: begin
				c.result_offset = '0;
			end
			1: begin
				c.result_offset = '1;
			end
			default: begin
				c.result_offset = $urandom;
			end
		endcase
		return c;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Unused upper bits of the narrow registers carry random data.
	task automatic configure(input cfg_t c, input bit stray);
		logic [63:0] pad;
		pad = {$urandom, $urandom};
		if (stray) begin
			write_reg(CFG_IDX_W'(REG_OFFSET + 1 + $urandom_range(0, 1)), pad);
		end
		write_reg(REG_PAT_LOW, c.pattern_bytes_low);
		write_reg(REG_PAT_HIGH, c.pattern_bytes_high);
		write_reg(REG_WILDCARD, {pad[63:16], c.wildcard_mask});
		write_reg(REG_PAT_LEN, {pad[63:5], c.pat_len});
		write_reg(REG_BASE, {pad[63:32], c.image_base});
		write_reg(REG_OFFSET, {pad[31:0], c.result_offset});
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] value, input logic closing);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{data_byte: value, last_byte: closing};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_image(input logic [7:0] image [$]);
		for (int i = 0; i < image.size(); i++) begin
			send_byte(image[i], i == image.size() - 1);
		end
	endtask

	// Most images carry one copy of the pattern at a random place.
	task automatic random_image(input cfg_t c, input bit narrow);
		logic [7:0] image [$];
		logic [127:0] pattern;
		int image_len;
		int len;
		int at;
		pattern = {c.pattern_bytes_high, c.pattern_bytes_low};
		len = c.pat_len;
		image_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 20);
		for (int i = 0; i < image_len; i++) begin
			image = {image, fill_byte(narrow)};
		end
		if (len >= 1 && len <= PAT_BYTES && len <= image_len && $urandom_range(0, 9) < 7) begin
			at = $urandom_range(0, image_len - len);
			for (int j = 0; j < len; j++) begin
				if (!c.wildcard_mask[j]) begin
					image[at + j] = pattern[8 * j +: 8];
				end
			end
		end
		send_image(image);
	endtask

	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		cfg_t setup;
		logic [7:0] image [$];
		bit narrow;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		setup = '0;
		setup.pattern_bytes_low = 64'h00000000_EFBEADDE;
		setup.pat_len = 5'd4;
		setup.image_base = 32'h0000_1000;
		setup.result_offset = 32'h0000_0010;
		configure(setup, 1'b1);
		send_image({8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h11});
		send_image({8'hDE, 8'hAD, 8'hBE, 8'hEF});
		send_image({8'h01, 8'h02, 8'h03});

		settle();
		setup.pattern_bytes_low = '1;
		setup.pattern_bytes_high = '1;
		setup.wildcard_mask = 16'h8001;
		setup.pat_len = LEN_W'(PAT_BYTES);
		setup.image_base = '1;
		setup.result_offset = '1;
		configure(setup, 1'b0);
		image = {image, 8'h00};
		repeat (PAT_BYTES - 2) image = {image, 8'hFF};
		image = {image, 8'h00};
		send_image(image);

		settle();
		setup.pat_len = '0;
		configure(setup, 1'b0);
		send_image({8'hFF});
		settle();
		setup.pat_len = LEN_W'(PAT_BYTES + 1);
		configure(setup, 1'b1);
		send_image({8'hFF});
		settle();
		setup.pat_len = '1;
		configure(setup, 1'b0);
		send_image({8'hFF});

		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			narrow = $urandom_range(0, 1);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			setup = random_setup(narrow);
			settle();
			configure(setup, $urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) random_image(setup, narrow);
		end

		settle();
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/wbps_pkg.sv
rtl/core/wbps_cfg.sv
rtl/core/wbps_match.sv
rtl/core/wildcard_byte_pattern_scanner_core.sv
tb/signature_scan_checker.sv
tb/testbench.sv
